### hw/rtl/jsv_pkg.sv
// Shared types and constants for the Josephus survivor block.
`default_nettype none
package jsv_pkg;

   localparam int unsigned SIZE_W           = 11;
   localparam int unsigned STEP_W           = 16;
   localparam int unsigned DEFAULT_MAX_RING = 1024;
   // largest ring size the size field can carry
   localparam int unsigned SIZE_LIMIT       = (2 ** SIZE_W) - 1;
   localparam int unsigned QUEUE_DEPTH      = 2;
   // dividend is position plus step
   localparam int unsigned DIVIDEND_W       = STEP_W + 1;

   typedef struct packed {
      logic [SIZE_W-1:0] ring_size;
      logic [STEP_W-1:0] step;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] survivor;
      logic              bad_size;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [STEP_W-1:0] stride;
      logic              bad;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### hw/rtl/jsv_front.sv
// Front end: takes request beats, flags a zero ring, clamps size and step.
`default_nettype none
module jsv_front #(
   parameter int unsigned MAX_RING = jsv_pkg::DEFAULT_MAX_RING
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire jsv_pkg::req_type req_data,
   output logic                 job_valid,
   input  wire logic            job_ready,
   output jsv_pkg::job_type     job_data
);

   localparam int unsigned CAP =
      (MAX_RING < jsv_pkg::SIZE_LIMIT) ? MAX_RING : jsv_pkg::SIZE_LIMIT;
   localparam logic [jsv_pkg::SIZE_W-1:0] CAP_N = jsv_pkg::SIZE_W'(CAP);

   logic             valid_ff, valid_in;
   jsv_pkg::job_type job_ff, job_in;
   logic             req_fire;

   assign req_ready = !valid_ff || job_ready;
   assign req_fire  = req_valid && req_ready;
   assign job_valid = valid_ff;
   assign job_data  = job_ff;

   always_comb begin
      valid_in = req_fire || (valid_ff && !job_ready);
      job_in   = job_ff;
      if (req_fire) begin
         job_in.bad    = (req_data.ring_size == '0);
         job_in.size   = (req_data.ring_size > CAP_N) ? CAP_N : req_data.ring_size;
         job_in.stride = (req_data.step == '0) ? jsv_pkg::STEP_W'(1) : req_data.step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule
`default_nettype wire

### hw/rtl/jsv_fifo.sv
// Short job queue between front and back end.
`default_nettype none
module jsv_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire jsv_pkg::job_type push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output jsv_pkg::job_type      pop_data
);

   localparam int unsigned DEPTH = jsv_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   jsv_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/jsv_back.sv
// Back end: runs the survivor recurrence with a bit-serial remainder unit.
`default_nettype none
module jsv_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_ready,
   input  wire jsv_pkg::job_type job_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output jsv_pkg::rsp_type      rsp_data
);

   localparam int unsigned SW    = jsv_pkg::SIZE_W;
   localparam int unsigned DW    = jsv_pkg::DIVIDEND_W;
   localparam int unsigned CNT_W = $clog2(DW);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DW - 1);

   jsv_pkg::state_type state_ff, state_in;

   logic [SW-1:0]          size_ff;
   logic [jsv_pkg::STEP_W-1:0] stride_ff;
   logic                   bad_ff;
   logic [SW-1:0]          pos_ff, len_ff;
   logic [DW-1:0]          dvd_ff;
   logic [SW-1:0]          rem_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   jsv_pkg::rsp_type       rsp_ff;

   logic       pop, div_load, div_shift, result_load, slot_free;
   logic       last_bit, last_len, trivial;
   logic [SW:0] trial, trial_sub;
   logic [SW-1:0] rem_next;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_bit  = (cnt_ff == '0);
   assign last_len  = (len_ff == size_ff);
   assign trivial   = job_data.bad || (job_data.size == SW'(1));

   assign trial     = {rem_ff, dvd_ff[DW-1]};
   assign trial_sub = trial - {1'b0, len_ff};
   assign rem_next  = (trial >= {1'b0, len_ff}) ? trial_sub[SW-1:0] : trial[SW-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jsv_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = trivial ? jsv_pkg::ST_DONE : jsv_pkg::ST_STEP;
            end
         end
         jsv_pkg::ST_STEP: state_in = jsv_pkg::ST_DIV;
         jsv_pkg::ST_DIV: begin
            if (last_bit) begin
               state_in = last_len ? jsv_pkg::ST_DONE : jsv_pkg::ST_STEP;
            end
         end
         jsv_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = jsv_pkg::ST_IDLE;
            end
         end
         default: state_in = jsv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      div_load    = 1'b0;
      div_shift   = 1'b0;
      result_load = 1'b0;
      case (state_ff)
         jsv_pkg::ST_IDLE: pop         = job_valid;
         jsv_pkg::ST_STEP: div_load    = 1'b1;
         jsv_pkg::ST_DIV:  div_shift   = 1'b1;
         jsv_pkg::ST_DONE: result_load = slot_free;
         default: ;
      endcase
   end

   assign job_ready = (state_ff == jsv_pkg::ST_IDLE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jsv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         size_ff   <= job_data.size;
         stride_ff <= job_data.stride;
         bad_ff    <= job_data.bad;
         pos_ff    <= '0;
         len_ff    <= SW'(2);
      end
      if (div_load) begin
         dvd_ff <= DW'(pos_ff) + DW'(stride_ff);
         rem_ff <= '0;
         cnt_ff <= CNT_TOP;
      end
      if (div_shift) begin
         dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (last_bit) begin
            pos_ff <= rem_next;
            len_ff <= len_ff + SW'(1);
         end
      end
      if (result_load) begin
         rsp_ff.survivor <= bad_ff ? '0 : pos_ff + SW'(1);
         rsp_ff.bad_size <= bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### hw/rtl/josephus_survivor.sv
// Flow: each request beat passes the front register and the queue, then the back end runs the
//   survivor recurrence for ring size n (n clamped to MAX_RING); each recurrence step is a load
//   state followed by the bit-serial remainder unit.
// Overlap: the back end works on one request at a time; a two-entry queue
//   and the front register let new beats in while a result waits on rsp_ready.
// Reset: synchronous, active high; clears handshake and control state only.
`default_nettype none
module josephus_survivor #(
   parameter int unsigned MAX_RING = jsv_pkg::DEFAULT_MAX_RING
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire jsv_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output jsv_pkg::rsp_type      rsp_data
);

   logic             fq_valid, fq_ready;
   jsv_pkg::job_type fq_data;
   logic             qb_valid, qb_ready;
   jsv_pkg::job_type qb_data;

   jsv_front #(
      .MAX_RING (MAX_RING)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   jsv_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   jsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
